FILE: hdl/tms_pkg.sv
package tms_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int NUM_FIXED = 4;
    localparam int NUM_SEG   = NUM_FIXED + NUM_SLOTS + 1;
    localparam int PAD_SEG   = NUM_SEG - 1;
    localparam int SEG_W     = $clog2(NUM_SEG);

    // fixed segment slots in emission order
    localparam int SEG_NODE_ID  = 0;
    localparam int SEG_NODE_CNT = 1;
    localparam int SEG_INGRESS  = 2;
    localparam int SEG_EGRESS   = 3;
    localparam int SEG_SLOT0    = NUM_FIXED;

    localparam int LEN_W    = 4;
    localparam int CNT_W    = 3;
    localparam int CODE_W   = 3;
    localparam int SUM_W    = 6;
    localparam int MAX_CODE = 4;

    localparam logic [LEN_W-1:0] NODE_ID_BYTES = 4'd4;
    localparam logic [LEN_W-1:0] SHORT_BYTES   = 4'd2;
    localparam logic [1:0]       ALIGN_BIAS    = 2'd2;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [3:0]  present_bits;
        logic [31:0] node_id;
        logic [15:0] node_count;
        logic [15:0] ingress_port;
        logic [15:0] egress_port;
        logic [11:0] slot_len_codes;
        logic [63:0] slot0_value;
        logic [63:0] slot1_value;
        logic [63:0] slot2_value;
        logic [63:0] slot3_value;
    } rec_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_padding;
        logic       bad_size;
        logic       last_byte;
    } meta_t;

    // classified record: one value and byte count per segment
    typedef struct packed {
        logic [NUM_SEG-1:0][63:0]      vals;
        logic [NUM_SEG-1:0][LEN_W-1:0] lens;
        logic                          bad;
    } job_t;

endpackage

FILE: hdl/tms_front.sv
module tms_front
    import tms_pkg::*;
(
    input  logic rec_valid,
    input  rec_t rec,
    input  logic full,
    output logic rec_stall,
    output logic push,
    output job_t job
);

    logic [3:0][63:0]  slot_vals;
    logic [CODE_W-1:0] code;
    logic [SUM_W-1:0]  total;
    logic [1:0]        tail;
    logic [1:0]        pad;

    assign rec_stall = full;
    assign push      = rec_valid && !full;

    always_comb
    begin
        slot_vals[0] = rec.slot0_value;
        slot_vals[1] = rec.slot1_value;
        slot_vals[2] = rec.slot2_value;
        slot_vals[3] = rec.slot3_value;

        job.bad = 1'b0;
        job.vals[SEG_NODE_ID]  = 64'(rec.node_id);
        job.vals[SEG_NODE_CNT] = 64'(rec.node_count);
        job.vals[SEG_INGRESS]  = 64'(rec.ingress_port);
        job.vals[SEG_EGRESS]   = 64'(rec.egress_port);
        job.lens[SEG_NODE_ID]  = rec.present_bits[0] ? NODE_ID_BYTES : '0;
        job.lens[SEG_NODE_CNT] = rec.present_bits[1] ? SHORT_BYTES : '0;
        job.lens[SEG_INGRESS]  = rec.present_bits[2] ? SHORT_BYTES : '0;
        job.lens[SEG_EGRESS]   = rec.present_bits[3] ? SHORT_BYTES : '0;

        code = '0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            code = rec.slot_len_codes[CODE_W*k +: CODE_W];
            job.vals[SEG_SLOT0+k] = slot_vals[k];
            if (code > CODE_W'(MAX_CODE))
            begin
                // oversized slot sends nothing, flagged on the last byte
                job.bad = 1'b1;
                job.lens[SEG_SLOT0+k] = '0;
            end
            else
            begin
                job.lens[SEG_SLOT0+k] = {code, 1'b0};
            end
        end

        total = '0;
        for (int s = 0; s < PAD_SEG; s++)
        begin
            total = total + SUM_W'(job.lens[s]);
        end

        // pad until count plus two is a multiple of four
        tail = total[1:0] + ALIGN_BIAS;
        pad  = 2'd0 - tail;
        job.vals[PAD_SEG] = '0;
        job.lens[PAD_SEG] = LEN_W'(pad);
    end

endmodule

FILE: hdl/tms_queue.sv
module tms_queue
    import tms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t head,
    output logic head_valid,
    output logic full
);

    job_t              slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = slots_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QDEPTH));

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

FILE: hdl/tms_back.sv
module tms_back
    import tms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  job_t  head,
    input  logic  head_valid,
    output logic  pop,
    output logic  meta_valid,
    input  logic  meta_stall,
    output meta_t meta
);

    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    meta_t            meta_reg, meta_next;

    logic [NUM_SEG-1:0] live;
    logic [SEG_W-1:0]   cur;
    logic               more;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   last_idx;
    logic [CNT_W-1:0]   pos;
    logic [63:0]        cur_val;
    logic               seg_end;
    logic               rec_end;
    logic               emit;

    assign meta_valid = valid_reg;
    assign meta       = meta_reg;

    always_comb
    begin
        // segments still to send, then the first of them
        for (int s = 0; s < NUM_SEG; s++)
        begin
            live[s] = (head.lens[s] != '0) && (SEG_W'(s) >= seg_reg);
        end
        cur = '0;
        for (int s = NUM_SEG - 1; s >= 0; s--)
        begin
            if (live[s])
            begin
                cur = SEG_W'(s);
            end
        end
        more = 1'b0;
        for (int s = 0; s < NUM_SEG; s++)
        begin
            if (live[s] && (SEG_W'(s) > cur))
            begin
                more = 1'b1;
            end
        end

        cur_len  = head.lens[cur];
        cur_val  = head.vals[cur];
        last_idx = cur_len - 1'b1;
        pos      = CNT_W'(last_idx - LEN_W'(cnt_reg));
        seg_end  = (LEN_W'(cnt_reg) == last_idx);
        rec_end  = seg_end && !more;

        emit = head_valid && (!valid_reg || !meta_stall);
        pop  = emit && rec_end;

        meta_next            = meta_reg;
        valid_next           = valid_reg && meta_stall;
        seg_next             = seg_reg;
        cnt_next             = cnt_reg;
        if (emit)
        begin
            valid_next           = 1'b1;
            meta_next.out_byte   = cur_val[8*pos +: 8];
            meta_next.is_padding = (cur == SEG_W'(PAD_SEG));
            meta_next.bad_size   = rec_end && head.bad;
            meta_next.last_byte  = rec_end;
            if (rec_end)
            begin
                seg_next = '0;
                cnt_next = '0;
            end
            else if (seg_end)
            begin
                seg_next = cur + 1'b1;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg   <= seg_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
    end

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && meta_reg.is_padding |-> meta_reg.out_byte == '0)
        else $error("pad byte not zero");

    a_bad_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && meta_reg.bad_size |-> meta_reg.last_byte)
        else $error("bad_size away from last byte");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> seg_reg == '0 && cnt_reg == '0)
        else $error("walk not restarted after record");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> meta_reg.last_byte == $past(pop))
        else $error("last byte and pop disagree");

endmodule

FILE: hdl/telemetry_metadata_serializer_core.sv
// a record accepted into the record queue has its bytes registered one by one into the meta output register
// throughput: one byte per cycle while meta_stall is low; a record of n bytes (2 to 42) holds the
//   byte walker until its last byte is sent, and a record already queued follows it with no gap
// the two-entry record queue lets the record side run up to two records ahead
// reset clears queue pointers, the byte walker and the output valid; payload
//   registers are not reset
module telemetry_metadata_serializer_core
    import tms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  rec_valid,
    output logic  rec_stall,
    input  rec_t  rec,
    output logic  meta_valid,
    input  logic  meta_stall,
    output meta_t meta
);

    // front side: classify the record into segments with byte counts
    job_t new_job;
    job_t head;
    logic push;
    logic pop;
    logic full;
    logic head_valid;

    tms_front u_front (
        .rec_valid (rec_valid),
        .rec       (rec),
        .full      (full),
        .rec_stall (rec_stall),
        .push      (push),
        .job       (new_job)
    );

    // short queue decoupling record intake from byte output
    tms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (new_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // back side: walk the head record one byte a cycle, while meta_stall is low, into the output register
    tms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .meta_valid (meta_valid),
        .meta_stall (meta_stall),
        .meta       (meta)
    );

endmodule

FILE: tb/telemetry_metadata_serializer_core_tb.sv
module telemetry_metadata_serializer_core_tb;

    import tms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 200;
    localparam int NUM_ITEMS    = NUM_DIRECTED + NUM_RANDOM;
    // quiet window after the last owed byte to catch stray bytes
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    // hand-typed bytes for the rows that need no predictor
    localparam meta_t NO_BYTE     = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam meta_t PAD_MID     = '{8'h00, 1'b1, 1'b0, 1'b0};
    localparam meta_t PAD_END     = '{8'h00, 1'b1, 1'b0, 1'b1};
    localparam meta_t PAD_END_BAD = '{8'h00, 1'b1, 1'b1, 1'b1};
    localparam meta_t ONES_MID    = '{8'hFF, 1'b0, 1'b0, 1'b0};
    localparam meta_t ONES_END    = '{8'hFF, 1'b0, 1'b0, 1'b1};

    // one row of the directed table: known_n of zero means use the predictor
    typedef struct packed {
        rec_t        rec;
        logic [2:0]  known_n;
        meta_t [3:0] known;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  rec_valid;
    logic  rec_stall;
    rec_t  rec;
    logic  meta_valid;
    logic  meta_stall;
    meta_t meta;

    // bytes still owed by the block, oldest first
    meta_t expected_bytes[$];
    int    mismatch_count = 0;

    // traffic phase: 0 sender light / receiver heavy idling, 1 swapped, 2 none
    int    phase = 0;

    stim_row_t directed[NUM_DIRECTED];

    telemetry_metadata_serializer_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec        (rec),
        .meta_valid (meta_valid),
        .meta_stall (meta_stall),
        .meta       (meta)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic rec_t mk_rec(
        input logic [3:0]  present,
        input logic [31:0] id,
        input logic [15:0] cnt,
        input logic [15:0] ingress,
        input logic [15:0] egress,
        input logic [11:0] codes,
        input logic [63:0] s0,
        input logic [63:0] s1,
        input logic [63:0] s2,
        input logic [63:0] s3
    );
        rec_t r;
        r.present_bits   = present;
        r.node_id        = id;
        r.node_count     = cnt;
        r.ingress_port   = ingress;
        r.egress_port    = egress;
        r.slot_len_codes = codes;
        r.slot0_value    = s0;
        r.slot1_value    = s1;
        r.slot2_value    = s2;
        r.slot3_value    = s3;
        return r;
    endfunction

    // random record: mostly legal length codes, now and then an oversized one,
    // and sometimes a fully random code word
    function automatic rec_t random_record();
        rec_t       r;
        logic [2:0] code;
        r.present_bits = 4'($urandom_range(15));
        r.node_id      = $urandom;
        r.node_count   = 16'($urandom);
        r.ingress_port = 16'($urandom);
        r.egress_port  = 16'($urandom);
        r.slot0_value  = {$urandom, $urandom};
        r.slot1_value  = {$urandom, $urandom};
        r.slot2_value  = {$urandom, $urandom};
        r.slot3_value  = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
        begin
            r.slot_len_codes = 12'($urandom_range(4095));
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                if ($urandom_range(9) == 0)
                    code = 3'($urandom_range(7, 5));
                else
                    code = 3'($urandom_range(4));
                r.slot_len_codes[3*k +: 3] = code;
            end
        end
        return r;
    endfunction

    // work out the byte stream of one record and queue it
    function automatic void predict_record(input rec_t r);
        logic [7:0][63:0] seg_val;
        int               seg_len[8];
        logic [3:0][63:0] slot_vals;
        logic [2:0]       code;
        logic             bad;
        int               n;
        int               pad;
        meta_t            m;
        meta_t            stream[$];

        slot_vals = {r.slot3_value, r.slot2_value, r.slot1_value, r.slot0_value};
        bad = 1'b0;

        // optional fixed fields in emission order
        seg_val[0] = 64'(r.node_id);
        seg_len[0] = r.present_bits[0] ? 4 : 0;
        seg_val[1] = 64'(r.node_count);
        seg_len[1] = r.present_bits[1] ? 2 : 0;
        seg_val[2] = 64'(r.ingress_port);
        seg_len[2] = r.present_bits[2] ? 2 : 0;
        seg_val[3] = 64'(r.egress_port);
        seg_len[3] = r.present_bits[3] ? 2 : 0;

        // data slots: oversized codes drop the slot and flag the record
        for (int k = 0; k < 4; k++)
        begin
            seg_val[4+k] = slot_vals[k];
            seg_len[4+k] = 0;
            code = r.slot_len_codes[3*k +: 3];
            if (k < NUM_SLOTS)
            begin
                if (code > 3'(MAX_CODE))
                    bad = 1'b1;
                else
                    seg_len[4+k] = 2 * int'(code);
            end
        end

        // big-endian: most significant byte of each field first
        for (int s = 0; s < 8; s++)
        begin
            for (int i = seg_len[s] - 1; i >= 0; i--)
            begin
                m = '{seg_val[s][8*i +: 8], 1'b0, 1'b0, 1'b0};
                stream.push_back(m);
            end
        end

        // zero pad until count plus two lands on a 4-byte boundary
        n = stream.size();
        pad = (4 - ((n + 2) % 4)) % 4;
        for (int i = 0; i < pad; i++)
        begin
            stream.push_back(PAD_MID);
        end

        m = stream.pop_back();
        m.last_byte = 1'b1;
        m.bad_size  = bad;
        stream.push_back(m);

        foreach (stream[i])
            expected_bytes.push_back(stream[i]);
    endfunction

    // offer one record after a random gap, wait for it to be taken
    task automatic send_record(input rec_t r, input logic [2:0] known_n,
                               input meta_t [3:0] known);
        int idle_pct;
        idle_pct = (phase == 0) ? 15 : (phase == 1) ? 60 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            rec_valid <= 1'b0;
            @(negedge clk);
        end
        rec       <= r;
        rec_valid <= 1'b1;
        // accepted at a rising edge with stall low; sample pre-edge values
        do
            @(posedge clk);
        while (rec_stall);
        if (known_n != 0)
        begin
            for (int i = 0; i < int'(known_n); i++)
                expected_bytes.push_back(known[i]);
        end
        else
        begin
            predict_record(r);
        end
        @(negedge clk);
    endtask

    // receiver: random stall per cycle by phase, plus one long hold-off at the
    // start of the no-idle phase so the record queue fills and stalls input
    initial
    begin
        int  idle_pct;
        bit  held;
        held       = 1'b0;
        meta_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (phase == 2 && !held)
            begin
                held = 1'b1;
                for (int c = 0; c < HOLD_CYCLES; c++)
                begin
                    meta_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            idle_pct = (phase == 0) ? 60 : (phase == 1) ? 15 : 0;
            meta_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // result checker: every accepted byte against the oldest expectation
    always @(posedge clk)
    begin
        meta_t want;
        if (rst_n && meta_valid && !meta_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected meta item: byte %0h pad %0b bad %0b last %0b",
                       meta.out_byte, meta.is_padding, meta.bad_size,
                       meta.last_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (meta.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h",
                           want.out_byte, meta.out_byte);
                    mismatch_count++;
                end
                if (meta.is_padding !== want.is_padding)
                begin
                    $error("is_padding: expected %0b, got %0b",
                           want.is_padding, meta.is_padding);
                    mismatch_count++;
                end
                if (meta.bad_size !== want.bad_size)
                begin
                    $error("bad_size: expected %0b, got %0b",
                           want.bad_size, meta.bad_size);
                    mismatch_count++;
                end
                if (meta.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %0b, got %0b",
                           want.last_byte, meta.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence: reset, directed table, random records, drain
    initial
    begin
        logic [63:0] ones;
        logic [63:0] ramp;
        ones = '1;
        ramp = 64'h0123_4567_89AB_CDEF;

        rst_n     = 1'b0;
        rec_valid = 1'b0;
        rec       = '0;

        // empty record: just two pad bytes
        directed[0]  = '{mk_rec(4'h0, 0, 0, 0, 0, 12'h000, 0, 0, 0, 0), 3'd2,
                         {NO_BYTE, NO_BYTE, PAD_END, PAD_MID}};
        // every slot oversized: slots dropped, flag on the last pad byte
        directed[1]  = '{mk_rec(4'h0, '1, '1, '1, '1, 12'hFFF, ones, ones, ones, ones),
                         3'd2, {NO_BYTE, NO_BYTE, PAD_END_BAD, PAD_MID}};
        directed[2]  = '{mk_rec(4'h2, 0, 16'hFFFF, 0, 0, 12'h000, 0, 0, 0, 0), 3'd2,
                         {NO_BYTE, NO_BYTE, ONES_END, ONES_MID}};
        directed[3]  = '{mk_rec(4'h0, 0, 0, 0, 0, 12'h001, ones, 0, 0, 0), 3'd2,
                         {NO_BYTE, NO_BYTE, ONES_END, ONES_MID}};
        // codes of six only, nothing else present
        directed[4]  = '{mk_rec(4'h0, 0, 0, 0, 0, 12'hDB6, ones, ones, ones, ones),
                         3'd2, {NO_BYTE, NO_BYTE, PAD_END_BAD, PAD_MID}};
        // the rest go through the predictor
        directed[5]  = '{mk_rec(4'hF, '1, '1, '1, '1, 12'h000, 0, 0, 0, 0), 3'd0, '0};
        directed[6]  = '{mk_rec(4'hF, 0, 0, 0, 0, 12'h000, 0, 0, 0, 0), 3'd0, '0};
        directed[7]  = '{mk_rec(4'h1, 32'hDEADBEEF, 0, 0, 0, 12'h000, 0, 0, 0, 0),
                         3'd0, '0};
        directed[8]  = '{mk_rec(4'h4, 0, 0, 16'h1234, 0, 12'h000, 0, 0, 0, 0),
                         3'd0, '0};
        directed[9]  = '{mk_rec(4'h8, 0, 0, 0, 16'hABCD, 12'h000, 0, 0, 0, 0),
                         3'd0, '0};
        // longest record: everything present, all slots eight bytes
        directed[10] = '{mk_rec(4'hF, '1, '1, '1, '1, 12'h924, ones, ones, ones, ones),
                         3'd0, '0};
        directed[11] = '{mk_rec(4'hF, 0, 0, 0, 0, 12'h924, 0, 0, 0, 0), 3'd0, '0};
        // six-byte slots keep only the low 48 bits
        directed[12] = '{mk_rec(4'h0, 0, 0, 0, 0, 12'h6DB, ramp, ~ramp, ones, ramp),
                         3'd0, '0};
        directed[13] = '{mk_rec(4'h3, 32'h89AB_CDEF, 16'h0102, 0, 0, 12'h492,
                                ramp, ~ramp, ramp, ~ramp), 3'd0, '0};
        directed[14] = '{mk_rec(4'hC, 0, 0, 16'h8001, 16'h7FFE, 12'h249,
                                ramp, ramp, ramp, ramp), 3'd0, '0};
        // oversized slots mixed with legal ones
        directed[15] = '{mk_rec(4'hF, 32'h0000_0001, 16'h8000, 16'h0001, 16'hFFFE,
                                12'h5A5, ramp, ~ramp, ones, ramp), 3'd0, '0};
        directed[16] = '{mk_rec(4'h0, 0, 0, 0, 0, 12'hA49, ones, ramp, ~ramp, ones),
                         3'd0, '0};
        directed[17] = '{mk_rec(4'h5, 32'hAAAA_AAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                                12'h0A3, {2{32'hAAAA_AAAA}}, {2{32'hAAAA_AAAA}},
                                {2{32'hAAAA_AAAA}}, {2{32'hAAAA_AAAA}}), 3'd0, '0};
        directed[18] = '{mk_rec(4'hA, 32'h5555_5555, 16'h5555, 16'h5555, 16'h5555,
                                12'h8E1, {2{32'h5555_5555}}, {2{32'h5555_5555}},
                                {2{32'h5555_5555}}, {2{32'h5555_5555}}), 3'd0, '0};
        directed[19] = '{mk_rec(4'h3, 32'hCAFE_F00D, 16'h00FF, 0, 0, 12'h007,
                                ones, ramp, ramp, ramp), 3'd0, '0};

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int idx = 0; idx < NUM_ITEMS; idx++)
        begin
            phase = (idx * 3) / NUM_ITEMS;
            if (idx < NUM_DIRECTED)
                send_record(directed[idx].rec, directed[idx].known_n,
                            directed[idx].known);
            else
                send_record(random_record(), 3'd0, '0);
        end
        rec_valid <= 1'b0;

        // let every owed byte come out, then watch for strays
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
